### design/zcdp_pkg.sv
// Shared types and constants of the ZIP central-directory parser.
package zcdp_pkg;

  // Fixed central-directory header
  localparam int unsigned PosW = 18;
  localparam logic [PosW-1:0] HDR_LEN = 18'd46;
  localparam logic [PosW-1:0] POS_SIG_LAST = 18'd3;
  localparam logic [PosW-1:0] POS_TAIL_SUM = 18'd34;
  localparam logic [PosW-1:0] POS_HDR_LAST = 18'd45;
  localparam logic [31:0] CD_SIGNATURE = 32'h02014b50;

  // Compression methods
  localparam logic [15:0] METHOD_STORED = 16'd0;
  localparam logic [15:0] METHOD_DEFLATED = 16'd8;

  // Characters that matter for the directory test
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_DOT = 8'h2e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_TRUNCATED  = 2'd2
  } status_e;

  // Register indexes
  typedef enum logic {
    REG_EXPECTED_ENTRIES = 1'b0,
    REG_BYTES_AVAILABLE  = 1'b1
  } reg_idx_e;

  localparam int unsigned PaddrW = 3;

  // Name normalization phases
  typedef enum logic [1:0] {
    STRIP_DOTSLASH = 2'd0,
    STRIP_DOT      = 2'd1,
    STRIP_SLASHES  = 2'd2,
    STRIP_KEPT     = 2'd3
  } strip_e;

  // Configuration handed from the register block to the parser
  typedef struct packed {
    logic [15:0] expected_entries;
    logic [31:0] bytes_available;
  } cfg_t;

endpackage

### design/zcdp_in_if.sv
// Input byte channel of the central-directory parser.
interface zcdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_directory;

  modport source (output valid, data_byte, start_of_directory, input ready);
  modport sink (input valid, data_byte, start_of_directory, output ready);
endinterface

### design/zcdp_out_if.sv
// Result channel of the central-directory parser.
interface zcdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] entry_index;
  logic [15:0] method_code;
  logic        method_supported;
  logic [31:0] packed_size;
  logic [31:0] plain_size;
  logic [15:0] name_length;
  logic [31:0] lfh_offset;
  logic        dir_flag;
  logic        last_record;

  modport source (
    output valid, status, entry_index, method_code, method_supported,
           packed_size, plain_size, name_length, lfh_offset,
           dir_flag, last_record,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, method_code, method_supported,
           packed_size, plain_size, name_length, lfh_offset,
           dir_flag, last_record,
    output ready
  );
endinterface

### design/zcdp_apb_regs.sv
// APB configuration registers of the central-directory parser.
module zcdp_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [zcdp_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output zcdp_pkg::cfg_t               cfg_o
);
  import zcdp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_EXPECTED_ENTRIES: cfg_q.expected_entries <= pwdata[15:0];
        REG_BYTES_AVAILABLE:  cfg_q.bytes_available <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_EXPECTED_ENTRIES: prdata = {16'd0, cfg_q.expected_entries};
      REG_BYTES_AVAILABLE:  prdata = cfg_q.bytes_available;
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/zip_central_directory_parser_core.sv
// ZIP central-directory parser: one byte per beat in, one result per record out.
// Usage:
//   in_i carries the central directory one byte per beat; start_of_directory marks
//   the first byte and clears the counters, the halt and the record position.
//   out_o carries one result at the last byte of each record, or one error result
//   (bad signature, header past archive end, truncated record), after which the
//   parser ignores bytes until the next start mark. Through the APB port the user
//   must set expected_entries and bytes_available only while idle; not enforced.
// Timing:
//   A byte is taken into an input register and decoded combinationally; its result
//   (if any) lands in the output register. One byte is accepted every cycle unless a
//   result waits in the output register while out_o.ready is low.
// Reset:
//   rst_ni clears the valid flags, APB registers, record position and counters;
//   bytes seen before any start mark are parsed as the start of a directory.
// Stall:
//   While a result waits on out_o, the input register still takes one more byte;
//   then in_i.ready drops until out_o.ready frees the output register.
module zip_central_directory_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  zcdp_in_if.sink                      in_i,
  zcdp_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [zcdp_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import zcdp_pkg::*;

  localparam logic [32:0] HdrLen33 = 33'd46;

  typedef struct packed {
    status_e     status;
    logic [15:0] entry_index;
    logic [15:0] method_code;
    logic        method_supported;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [15:0] name_length;
    logic [31:0] lfh_offset;
    logic        dir_flag;
    logic        last_record;
  } res_t;

  cfg_t cfg;

  zcdp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       advance;

  // Parser state
  logic [PosW-1:0] pos_q, pos_d, pos_e;
  logic [32:0]     base_q, base_d, base_e;     // record start plus header length
  logic [15:0]     entries_q, entries_d, entries_e;
  logic            halted_q, halted_d, halted_e;
  strip_e          phase_q, phase_d, phase_e;
  logic            slash_q, slash_d, slash_e;

  // Captured header fields
  logic [23:0]     sig_q;
  logic [15:0]     method_q;
  logic [31:0]     csize_q;
  logic [31:0]     usize_q;
  logic [15:0]     name_len_q;
  logic [15:0]     extra_len_q;
  logic [15:0]     comment_len_q;
  logic [31:0]     offset_q;
  logic [PosW-1:0] tail_sum_q;
  logic [PosW-1:0] name_end_q;
  logic [PosW-1:0] rec_end_q;

  // Output stage
  logic out_valid_q;
  res_t res_q, res_d;
  logic emit;

  // Decode helpers
  logic            active;
  logic            in_header;
  logic [7:0]      norm_byte;
  logic [32:0]     hdr_end_sum;
  logic [31:0]     offset_now;
  logic [15:0]     entries_inc;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Load the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.start_of_directory;
    end
  end

  // A start mark restarts the directory before the byte is parsed
  always_comb begin
    if (in_start_q) begin
      pos_e     = '0;
      base_e    = HdrLen33;
      entries_e = '0;
      halted_e  = 1'b0;
      phase_e   = STRIP_DOTSLASH;
      slash_e   = 1'b0;
    end else begin
      pos_e     = pos_q;
      base_e    = base_q;
      entries_e = entries_q;
      halted_e  = halted_q;
      phase_e   = phase_q;
      slash_e   = slash_q;
    end
  end

  assign active      = !halted_e && (entries_e < cfg.expected_entries);
  assign in_header   = pos_e < HDR_LEN;
  assign norm_byte   = (in_byte_q == CHAR_BSLASH) ? CHAR_SLASH : in_byte_q;
  assign hdr_end_sum = base_e + {15'd0, tail_sum_q};
  assign entries_inc = entries_e + 16'd1;
  assign offset_now  = (pos_e == POS_HDR_LAST) ? {in_byte_q, offset_q[23:0]} : offset_q;

  // Decode one byte: advance the record, track the name, build the result
  always_comb begin
    pos_d     = pos_e;
    base_d    = base_e;
    entries_d = entries_e;
    halted_d  = halted_e;
    phase_d   = phase_e;
    slash_d   = slash_e;
    emit      = 1'b0;
    res_d     = '0;
    res_d.entry_index = entries_e;

    if (active) begin
      // Normalize the name while its bytes pass
      if (!in_header && (pos_e < name_end_q)) begin
        unique case (phase_e)
          STRIP_DOTSLASH: begin
            if (norm_byte == CHAR_DOT) begin
              phase_d = STRIP_DOT;
            end else if (norm_byte == CHAR_SLASH) begin
              phase_d = STRIP_SLASHES;
            end else begin
              phase_d = STRIP_KEPT;
              slash_d = 1'b0;
            end
          end
          STRIP_DOT: begin
            if (norm_byte == CHAR_SLASH) begin
              phase_d = STRIP_DOTSLASH;
            end else begin
              phase_d = STRIP_KEPT;
              slash_d = 1'b0;
            end
          end
          STRIP_SLASHES: begin
            if (norm_byte != CHAR_SLASH) begin
              phase_d = STRIP_KEPT;
              slash_d = 1'b0;
            end
          end
          STRIP_KEPT: begin
            slash_d = (norm_byte == CHAR_SLASH);
          end
          default: ;
        endcase
      end

      priority if (in_header && (pos_e == '0) && (base_e > {1'b0, cfg.bytes_available})) begin
        emit         = 1'b1;
        res_d.status = STATUS_BAD_HEADER;
      end else if (in_header && (pos_e == POS_SIG_LAST) &&
                   ({in_byte_q, sig_q} != CD_SIGNATURE)) begin
        emit         = 1'b1;
        res_d.status = STATUS_BAD_HEADER;
      end else if (in_header && (pos_e == POS_HDR_LAST) &&
                   (hdr_end_sum > {1'b0, cfg.bytes_available})) begin
        emit         = 1'b1;
        res_d.status = STATUS_TRUNCATED;
      end else if ((in_header && (pos_e == POS_HDR_LAST) && (tail_sum_q == '0)) ||
                   (!in_header && (pos_e == rec_end_q))) begin
        emit                   = 1'b1;
        res_d.status           = STATUS_OK;
        res_d.method_code      = method_q;
        res_d.method_supported = (method_q == METHOD_STORED) ||
                                 (method_q == METHOD_DEFLATED);
        res_d.packed_size      = csize_q;
        res_d.plain_size       = usize_q;
        res_d.name_length      = name_len_q;
        res_d.lfh_offset       = offset_now;
        res_d.dir_flag         = (phase_d == STRIP_KEPT) && slash_d;
        res_d.last_record      = (entries_inc == cfg.expected_entries);
        entries_d              = entries_inc;
        base_d                 = hdr_end_sum + HdrLen33;
        pos_d                  = '0;
        phase_d                = STRIP_DOTSLASH;
        slash_d                = 1'b0;
      end else begin
        pos_d = pos_e + 18'd1;
      end

      // Error results carry only the status, the index and the last flag
      if (emit && (res_d.status != STATUS_OK)) begin
        res_d.last_record = 1'b1;
        halted_d          = 1'b1;
      end
    end
  end

  // Parser control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      base_q    <= HdrLen33;
      entries_q <= '0;
      halted_q  <= 1'b0;
      phase_q   <= STRIP_DOTSLASH;
      slash_q   <= 1'b0;
    end else if (advance) begin
      pos_q     <= pos_d;
      base_q    <= base_d;
      entries_q <= entries_d;
      halted_q  <= halted_d;
      phase_q   <= phase_d;
      slash_q   <= slash_d;
    end
  end

  // Capture little-endian header fields by position
  always_ff @(posedge clk_i) begin
    if (advance && active && in_header) begin
      unique case (pos_e[5:0])
        6'd0:  sig_q[7:0]          <= in_byte_q;
        6'd1:  sig_q[15:8]         <= in_byte_q;
        6'd2:  sig_q[23:16]        <= in_byte_q;
        6'd10: method_q[7:0]       <= in_byte_q;
        6'd11: method_q[15:8]      <= in_byte_q;
        6'd20: csize_q[7:0]        <= in_byte_q;
        6'd21: csize_q[15:8]       <= in_byte_q;
        6'd22: csize_q[23:16]      <= in_byte_q;
        6'd23: csize_q[31:24]      <= in_byte_q;
        6'd24: usize_q[7:0]        <= in_byte_q;
        6'd25: usize_q[15:8]       <= in_byte_q;
        6'd26: usize_q[23:16]      <= in_byte_q;
        6'd27: usize_q[31:24]      <= in_byte_q;
        6'd28: name_len_q[7:0]     <= in_byte_q;
        6'd29: name_len_q[15:8]    <= in_byte_q;
        6'd30: extra_len_q[7:0]    <= in_byte_q;
        6'd31: extra_len_q[15:8]   <= in_byte_q;
        6'd32: comment_len_q[7:0]  <= in_byte_q;
        6'd33: comment_len_q[15:8] <= in_byte_q;
        6'd34: begin
          // All lengths are known: precompute the tail bounds
          tail_sum_q <= {2'd0, name_len_q} + {2'd0, extra_len_q} + {2'd0, comment_len_q};
          name_end_q <= {2'd0, name_len_q} + HDR_LEN;
          rec_end_q  <= {2'd0, name_len_q} + {2'd0, extra_len_q} +
                        {2'd0, comment_len_q} + POS_HDR_LAST;
        end
        6'd42: offset_q[7:0]       <= in_byte_q;
        6'd43: offset_q[15:8]      <= in_byte_q;
        6'd44: offset_q[23:16]     <= in_byte_q;
        6'd45: offset_q[31:24]     <= in_byte_q;
        default: ;
      endcase
    end
  end

  // Output register: load on a result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = res_q.status;
  assign out_o.entry_index      = res_q.entry_index;
  assign out_o.method_code      = res_q.method_code;
  assign out_o.method_supported = res_q.method_supported;
  assign out_o.packed_size      = res_q.packed_size;
  assign out_o.plain_size       = res_q.plain_size;
  assign out_o.name_length      = res_q.name_length;
  assign out_o.lfh_offset       = res_q.lfh_offset;
  assign out_o.dir_flag         = res_q.dir_flag;
  assign out_o.last_record      = res_q.last_record;

endmodule
